### sv/abs_pkg.sv
package abs_pkg;

    typedef enum logic [1:0] {
        OP_MSG  = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOAD,
        ST_SEND
    } t_state;

    localparam logic [15:0] SUM_ALL_ONES = 16'hffff;

    localparam logic [0:0] REG_TIMEOUT = 1'b0;

    typedef struct packed {
        logic take_msg;
        logic take_ack;
        logic take_tick;
        logic fill_step;
        logic load_start;
        logic load_step;
        logic send_step;
        logic resend_start;
    } t_cmd;

    typedef struct packed {
        logic start_send;
        logic start_resend;
        logic fill_need;
        logic fill_done;
        logic load_done;
        logic send_done;
    } t_sts;

endpackage

### sv/abs_datapath.sv
module abs_datapath #(
    parameter int RING_MESSAGES = 128,
    parameter int MESSAGE_WORDS = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  abs_pkg::t_cmd  i_cmd,
    output abs_pkg::t_sts  o_sts,
    input  logic [15:0]    i_data_word,
    input  logic           i_word_last,
    input  logic [31:0]    i_rx_seq,
    input  logic [31:0]    i_rx_acknum,
    input  logic [15:0]    i_rx_checksum,
    input  logic [15:0]    i_timeout,
    input  logic           i_out_free,
    output logic           o_out_load,
    output logic           o_tx_seq,
    output logic [15:0]    o_tx_checksum,
    output logic [15:0]    o_tx_word,
    output logic           o_tx_last,
    output logic           o_resend,
    output logic [15:0]    o_dropped_messages
);
    localparam int SW = (RING_MESSAGES > 1) ? $clog2(RING_MESSAGES) : 1;
    localparam int PW = (MESSAGE_WORDS > 1) ? $clog2(MESSAGE_WORDS) : 1;
    localparam int CW = $clog2(RING_MESSAGES + 1);
    localparam int QW = $clog2(MESSAGE_WORDS + 1);
    localparam int AW = $clog2(RING_MESSAGES * MESSAGE_WORDS);
    localparam int DEPTH = RING_MESSAGES * MESSAGE_WORDS;

    logic [15:0] r_ring [DEPTH];
    logic [15:0] r_sums [RING_MESSAGES];
    logic [15:0] r_last_words [MESSAGE_WORDS];

    logic [1:0]    r_phase;
    logic [SW-1:0] r_wslot, r_rslot;
    logic [CW-1:0] r_count;
    logic [QW-1:0] r_wpos;
    logic          r_discard;
    logic [15:0]   r_msum, r_ack_sum, r_chk, r_timer, r_drops;
    logic          r_timer_run;
    logic [PW-1:0] r_lidx, r_sidx;
    logic          r_lpend;
    logic          r_resend_pkt;
    logic [15:0]   r_rdata;
    logic [15:0]   r_sum_rd;
    logic          r_pending_send;

    logic [AW-1:0] w_addr, rd_addr;
    logic          w_en;
    logic [15:0]   w_data;
    logic          msg_last, full_now, drop_now, store_word, will_commit;
    logic [15:0]   ack_total;
    logic          ack_ok;

    always_comb begin
        msg_last   = i_cmd.take_msg && i_word_last;
        full_now   = (r_wpos == '0) && !r_discard && (r_count == CW'(RING_MESSAGES));
        drop_now   = i_cmd.take_msg && full_now;
        store_word = i_cmd.take_msg && !full_now && !r_discard
                     && (r_wpos < QW'(MESSAGE_WORDS));
        will_commit = msg_last && !full_now && !r_discard;
        ack_total  = r_ack_sum + i_data_word + i_rx_seq[15:0] + i_rx_acknum[15:0]
                     + i_rx_checksum;
        ack_ok     = (ack_total == abs_pkg::SUM_ALL_ONES) && (i_rx_acknum == 32'd1)
                     && (i_rx_seq == {31'd0, r_phase[1]});
        w_en   = store_word || i_cmd.fill_step;
        w_data = i_cmd.fill_step ? 16'd0 : i_data_word;
        w_addr = AW'(32'(r_wslot) * MESSAGE_WORDS + 32'(r_wpos));
        rd_addr = AW'(32'(r_rslot) * MESSAGE_WORDS + 32'(r_lidx));
        o_sts.fill_need  = will_commit && (r_wpos < QW'(MESSAGE_WORDS - 1));
        o_sts.fill_done  = (r_wpos == QW'(MESSAGE_WORDS - 1));
        o_sts.start_send = r_pending_send;
        o_sts.start_resend = i_cmd.take_tick && r_phase[0] && r_timer_run
                             && (r_timer <= 16'd1);
        o_sts.load_done  = !r_lpend && (r_lidx == '0) && !i_cmd.load_start;
        o_sts.send_done  = i_out_free && (r_sidx == PW'(MESSAGE_WORDS - 1));
        o_out_load       = i_cmd.send_step && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ring[w_addr] <= w_data;
        end
        r_rdata <= r_ring[rd_addr];
        r_sum_rd <= r_sums[r_rslot];
        if (r_lpend) begin
            r_last_words[PW'(r_lidx - PW'(1))] <= r_rdata;
        end
        if ((will_commit && !o_sts.fill_need) || (i_cmd.fill_step && o_sts.fill_done)) begin
            r_sums[r_wslot] <= store_word ? r_msum + i_data_word : r_msum;
        end
        if (o_out_load) begin
            o_tx_seq      <= r_phase[1];
            o_tx_checksum <= r_chk;
            o_tx_word     <= r_last_words[r_sidx];
            o_tx_last     <= (r_sidx == PW'(MESSAGE_WORDS - 1));
            o_resend      <= r_resend_pkt;
            o_dropped_messages <= r_drops;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0; r_wslot <= '0; r_rslot <= '0; r_count <= '0;
            r_wpos <= '0; r_discard <= 1'b0; r_msum <= '0; r_ack_sum <= '0;
            r_chk <= '0; r_timer <= '0; r_drops <= '0; r_timer_run <= 1'b0;
            r_lidx <= '0; r_sidx <= '0; r_lpend <= 1'b0; r_resend_pkt <= 1'b0;
            r_pending_send <= 1'b0;
        end else begin
            if (i_cmd.load_start) begin
                r_pending_send <= 1'b0;
            end
            if (drop_now) begin
                if (r_drops != abs_pkg::SUM_ALL_ONES) r_drops <= r_drops + 16'd1;
                if (!i_word_last) r_discard <= 1'b1;
            end else if (i_cmd.take_msg && r_discard && i_word_last) begin
                r_discard <= 1'b0;
            end
            if (store_word) begin
                r_wpos <= r_wpos + QW'(1);
                r_msum <= r_msum + i_data_word;
            end
            if (i_cmd.fill_step) begin
                r_wpos <= r_wpos + QW'(1);
            end
            if ((will_commit && !o_sts.fill_need) || (i_cmd.fill_step && o_sts.fill_done)) begin
                r_wpos  <= '0;
                r_msum  <= '0;
                r_wslot <= (r_wslot == SW'(RING_MESSAGES - 1)) ? '0 : r_wslot + SW'(1);
                r_count <= r_count + CW'(1);
            end
            if (msg_last && !r_phase[0]) begin
                r_pending_send <= 1'b1;
            end
            if (i_cmd.take_ack) begin
                r_ack_sum <= i_word_last ? 16'd0 : r_ack_sum + i_data_word;
                if (i_word_last && r_phase[0] && ack_ok) begin
                    r_timer_run <= 1'b0;
                    r_timer <= '0;
                    r_phase <= {~r_phase[1], 1'b0};
                end
            end
            if (i_cmd.take_tick && r_phase[0] && r_timer_run && r_timer > 16'd1) begin
                r_timer <= r_timer - 16'd1;
            end
            if (i_cmd.load_start) begin
                r_lidx  <= PW'(1);
                r_lpend <= 1'b1;
                r_resend_pkt <= 1'b0;
                r_phase[0] <= 1'b1;
                r_count <= r_count - CW'(1);
            end else if (r_lpend) begin
                if (r_lidx == PW'(MESSAGE_WORDS) || MESSAGE_WORDS == 1) begin
                    r_lpend <= 1'b0;
                    r_lidx  <= '0;
                    r_chk   <= ~(16'(r_phase[1]) + r_sum_rd);
                    r_rslot <= (r_rslot == SW'(RING_MESSAGES - 1)) ? '0 : r_rslot + SW'(1);
                end else begin
                    r_lidx <= PW'(32'(r_lidx) + 1);
                end
            end
            if (i_cmd.resend_start) begin
                r_resend_pkt <= 1'b1;
            end
            if (o_out_load) begin
                if (r_sidx == PW'(MESSAGE_WORDS - 1)) begin
                    r_sidx <= '0;
                    r_timer_run <= 1'b1;
                    r_timer <= (i_timeout == 16'd0) ? 16'd1 : i_timeout;
                end else begin
                    r_sidx <= r_sidx + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            assert (!(r_count > CW'(RING_MESSAGES)))
                else $error("ring count overflow");
        end
    end

    a_no_fill_while_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.fill_step && r_lpend)) else $error("fill during load");
    a_commit_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_start) |=> r_phase[0]) else $error("phase not waiting");
    a_send_resets_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_load && r_sidx == PW'(MESSAGE_WORDS - 1)) |=> r_timer_run)
        else $error("timer not started");
endmodule

### sv/abs_ctrl.sv
module abs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_operation,
    output logic           o_stall,
    input  abs_pkg::t_sts  i_sts,
    output abs_pkg::t_cmd  o_cmd
);
    abs_pkg::t_state r_state, n_state;
    logic acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= abs_pkg::ST_IDLE;
        end else begin
            r_state  <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_stall  = 1'b1;
        acc      = 1'b0;
        case (r_state)
            abs_pkg::ST_IDLE: begin
                if (i_sts.start_send) begin
                    o_cmd.load_start = 1'b1;
                    n_state = abs_pkg::ST_LOAD;
                end else begin
                    o_stall = 1'b0;
                    acc = i_valid;
                    o_cmd.take_msg  = acc && (i_operation == abs_pkg::OP_MSG);
                    o_cmd.take_ack  = acc && (i_operation == abs_pkg::OP_ACK);
                    o_cmd.take_tick = acc && (i_operation == abs_pkg::OP_TICK);
                    if (i_sts.fill_need && o_cmd.take_msg) begin
                        n_state = abs_pkg::ST_FILL;
                    end else if (i_sts.start_resend) begin
                        o_cmd.resend_start = 1'b1;
                        n_state = abs_pkg::ST_SEND;
                    end
                end
            end
            abs_pkg::ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_done) n_state = abs_pkg::ST_IDLE;
            end
            abs_pkg::ST_LOAD: begin
                o_cmd.load_step = 1'b1;
                if (i_sts.load_done) n_state = abs_pkg::ST_SEND;
            end
            abs_pkg::ST_SEND: begin
                o_cmd.send_step = 1'b1;
                if (i_sts.send_done) n_state = abs_pkg::ST_IDLE;
            end
            default: n_state = abs_pkg::ST_IDLE;
        endcase
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == abs_pkg::ST_SEND) |-> o_stall) else $error("accept while sending");
    a_load_to_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_start) |=> (r_state == abs_pkg::ST_LOAD)) else $error("bad load");
    a_one_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.take_msg, o_cmd.take_ack, o_cmd.take_tick}))
        else $error("multiple takes");
endmodule

### sv/alternating_bit_sender.sv
// Stop-and-wait sender with an alternating sequence bit. Message words (operation 0) fill a
// ring of RING_MESSAGES messages; ack words (1) are checked and flip the bit; ticks (2) count
// down toward a retransmission. A request is accepted only while the controller is idle and
// no packet start is pending; a message whose last word comes early is zero-filled to
// MESSAGE_WORDS words. Starting a packet reads the ring through its single read port at one
// word per cycle, then the packet leaves at one word per cycle as the output register is
// freed. timeout_ticks sits at address 0. The ring has no clearing pass.
module alternating_bit_sender #(
    parameter int RING_MESSAGES = 128,
    parameter int MESSAGE_WORDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_data_word,
    input  logic        i_word_last,
    input  logic [31:0] i_rx_seq,
    input  logic [31:0] i_rx_acknum,
    input  logic [15:0] i_rx_checksum,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tx_seq,
    output logic [15:0] o_tx_checksum,
    output logic [15:0] o_tx_word,
    output logic        o_tx_last,
    output logic        o_resend,
    output logic [15:0] o_dropped_messages
);
    abs_pkg::t_cmd cmd;
    abs_pkg::t_sts sts;
    logic [15:0] r_timeout;
    logic        r_valid, out_load, out_free;

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == {abs_pkg::REG_TIMEOUT, 1'b0}) ? {16'd0, r_timeout} : 32'd0;
    assign out_free = !r_valid || !i_stall;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd6;
            r_valid   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == {abs_pkg::REG_TIMEOUT, 1'b0}) begin
                r_timeout <= pwdata[15:0];
            end
            if (out_load) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
        end
    end

    abs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_operation(i_operation),
        .o_stall(o_stall), .i_sts(sts), .o_cmd(cmd)
    );

    abs_datapath #(.RING_MESSAGES(RING_MESSAGES), .MESSAGE_WORDS(MESSAGE_WORDS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_data_word(i_data_word), .i_word_last(i_word_last),
        .i_rx_seq(i_rx_seq), .i_rx_acknum(i_rx_acknum), .i_rx_checksum(i_rx_checksum),
        .i_timeout(r_timeout), .i_out_free(out_free), .o_out_load(out_load),
        .o_tx_seq(o_tx_seq), .o_tx_checksum(o_tx_checksum), .o_tx_word(o_tx_word),
        .o_tx_last(o_tx_last), .o_resend(o_resend), .o_dropped_messages(o_dropped_messages)
    );
endmodule
